[hdl/brs_pkg.sv]
package brs_pkg;

  localparam int LENGTH_WIDTH = 32;
  localparam int WORD_BITS    = 64;
  localparam int IDX_W        = 6;
  localparam int START_W      = 6;
  localparam int LEN_IN_W     = 32;
  localparam int INDEX_W      = 32;
  // Stream positions cover start plus length, one bit more than the length.
  localparam int END_W        = LENGTH_WIDTH + 1;
  localparam int BASE_HI_W    = END_W - IDX_W;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [START_W-1:0]   start_offset;
    logic [LEN_IN_W-1:0]  length;
    logic                 seek_zero;
    logic                 from_top;
    logic                 first;
    logic                 last;
  } scan_item_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] bit_index;
  } scan_result_t;

  // One masked word on its way from the front to the back.
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [BASE_HI_W-1:0] base_hi;
    logic [START_W-1:0]   start;
    logic                 from_top;
    logic                 first;
    logic                 last;
  } work_t;

endpackage

[hdl/brs_front.sv]
module brs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  brs_pkg::scan_item_t scan_item,
  output logic                wr_en,
  output brs_pkg::work_t      ent
);

  localparam logic [brs_pkg::END_W-1:0] BASE_CAP =
    {{(brs_pkg::END_W-brs_pkg::IDX_W){1'b1}}, {brs_pkg::IDX_W{1'b0}}};
  localparam logic [brs_pkg::END_W-1:0] BASE_STEP =
    brs_pkg::END_W'(brs_pkg::WORD_BITS);

  logic [brs_pkg::END_W-1:0]   word_base;
  logic [brs_pkg::END_W-1:0]   range_end;
  logic [brs_pkg::START_W-1:0] range_start;
  logic [1:0]                  mode_flags;

  logic [brs_pkg::END_W-1:0]     len_ext;
  logic [brs_pkg::END_W-1:0]     end_in;
  logic [brs_pkg::END_W-1:0]     rem;
  logic                          in_range;
  logic [brs_pkg::START_W-1:0]   start_cur;
  logic [brs_pkg::IDX_W-1:0]     lo;
  logic                          seek_cur;
  logic                          top_cur;
  logic [brs_pkg::WORD_BITS-1:0] hi_mask;
  logic [brs_pkg::WORD_BITS-1:0] lo_mask;
  logic [brs_pkg::WORD_BITS-1:0] mask;
  logic [brs_pkg::WORD_BITS-1:0] w;

  assign wr_en = push && !full;

  always_comb begin
    len_ext   = brs_pkg::END_W'(scan_item.length[brs_pkg::LENGTH_WIDTH-1:0]);
    end_in    = brs_pkg::END_W'(scan_item.start_offset) + len_ext;
    start_cur = scan_item.first ? scan_item.start_offset : range_start;
    seek_cur  = scan_item.first ? scan_item.seek_zero : mode_flags[0];
    top_cur   = scan_item.first ? scan_item.from_top : mode_flags[1];
    // A new scan starts at stream position zero, so no subtraction is needed then.
    if (scan_item.first) begin
      rem      = end_in;
      in_range = end_in != '0;
    end else begin
      rem      = range_end - word_base;
      in_range = range_end > word_base;
    end
    // Only the word at stream position zero holds the start bit.
    lo = (scan_item.first || word_base == '0) ? start_cur : '0;
    if (rem >= BASE_STEP) begin
      hi_mask = '1;
    end else begin
      hi_mask = (brs_pkg::WORD_BITS'(1) << rem[brs_pkg::IDX_W-1:0]) - 1'b1;
    end
    lo_mask = ~((brs_pkg::WORD_BITS'(1) << lo) - 1'b1);
    mask    = in_range ? (hi_mask & lo_mask) : '0;
    w       = (seek_cur ? ~scan_item.word : scan_item.word) & mask;

    ent.word     = w;
    ent.base_hi  = scan_item.first ? '0 : word_base[brs_pkg::END_W-1:brs_pkg::IDX_W];
    ent.start    = start_cur;
    ent.from_top = top_cur;
    ent.first    = scan_item.first;
    ent.last     = scan_item.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_base   <= '0;
      range_end   <= '0;
      range_start <= '0;
      mode_flags  <= '0;
    end else if (wr_en) begin
      if (scan_item.first) begin
        word_base   <= BASE_STEP;
        range_end   <= end_in;
        range_start <= scan_item.start_offset;
        mode_flags  <= {scan_item.from_top, scan_item.seek_zero};
      end else if (word_base < BASE_CAP) begin
        word_base <= word_base + BASE_STEP;
      end
    end
  end

`ifndef SYNTHESIS
  a_zero_length_no_bits: assert property (@(posedge clk) disable iff (rst)
    (wr_en && scan_item.first && scan_item.length[brs_pkg::LENGTH_WIDTH-1:0] == '0)
      |-> ent.word == '0)
    else $error("zero-length range let bits through the mask");
`endif

endmodule

[hdl/brs_queue.sv]
module brs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  brs_pkg::work_t din,
  input  logic           rd_en,
  output brs_pkg::work_t dout,
  output logic           full,
  output logic           empty
);

  brs_pkg::work_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_queue_bounds: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && full) && !(rd_en && empty) && count != 2'd3)
    else $error("work queue overrun or underrun");
`endif

endmodule

[hdl/brs_back.sv]
module brs_back (
  input  logic                  clk,
  input  logic                  rst,
  input  brs_pkg::work_t        head,
  input  logic                  q_empty,
  output logic                  q_rd,
  input  logic                  pop,
  output logic                  empty,
  output brs_pkg::scan_result_t scan_result
);

  logic                              hit_valid;
  logic [brs_pkg::LENGTH_WIDTH-1:0]  hit_position;
  logic                              hit_valid_next;
  logic [brs_pkg::LENGTH_WIDTH-1:0]  hit_position_next;
  logic                              valid_cur;
  logic [brs_pkg::LENGTH_WIDTH-1:0]  pos_cur;
  logic [brs_pkg::IDX_W-1:0]         sel_idx;
  logic [brs_pkg::END_W-1:0]         stream_pos;
  logic [brs_pkg::LENGTH_WIDTH-1:0]  rel_pos;

  brs_pkg::scan_result_t res_mem [2];
  logic                  res_wr_ptr;
  logic                  res_rd_ptr;
  logic [1:0]            res_count;
  logic                  res_wr;
  logic                  res_rd;
  brs_pkg::scan_result_t res_new;

  function automatic logic [brs_pkg::IDX_W-1:0] low_set(
    input logic [brs_pkg::WORD_BITS-1:0] w
  );
    logic [brs_pkg::IDX_W-1:0] idx;
    idx = '0;
    for (int i = brs_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = brs_pkg::IDX_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [brs_pkg::IDX_W-1:0] high_set(
    input logic [brs_pkg::WORD_BITS-1:0] w
  );
    logic [brs_pkg::IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < brs_pkg::WORD_BITS; i++) begin
      if (w[i]) begin
        idx = brs_pkg::IDX_W'(i);
      end
    end
    return idx;
  endfunction

  // A word that closes a scan needs room for its result.
  assign q_rd   = !q_empty && (!head.last || res_count != 2'd2);
  assign res_wr = q_rd && head.last;
  assign res_rd = pop && !empty;
  assign empty  = res_count == 2'd0;
  assign scan_result = res_mem[res_rd_ptr];

  always_comb begin
    valid_cur  = head.first ? 1'b0 : hit_valid;
    pos_cur    = head.first ? '0 : hit_position;
    sel_idx    = head.from_top ? high_set(head.word) : low_set(head.word);
    // Word base is a multiple of the word size, so the bit index fills the low bits.
    stream_pos = {head.base_hi, sel_idx} - brs_pkg::END_W'(head.start);
    rel_pos    = stream_pos[brs_pkg::LENGTH_WIDTH-1:0];
    hit_valid_next    = valid_cur;
    hit_position_next = pos_cur;
    if (head.word != '0 && (head.from_top || !valid_cur)) begin
      hit_valid_next    = 1'b1;
      hit_position_next = rel_pos;
    end
    res_new.found     = hit_valid_next;
    res_new.bit_index = hit_valid_next ? brs_pkg::INDEX_W'(hit_position_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (res_wr) begin
      res_mem[res_wr_ptr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid    <= 1'b0;
      hit_position <= '0;
      res_wr_ptr   <= 1'b0;
      res_rd_ptr   <= 1'b0;
      res_count    <= 2'd0;
    end else begin
      if (q_rd) begin
        hit_valid    <= hit_valid_next;
        hit_position <= hit_position_next;
      end
      if (res_wr) begin
        res_wr_ptr <= ~res_wr_ptr;
      end
      if (res_rd) begin
        res_rd_ptr <= ~res_rd_ptr;
      end
      case ({res_wr, res_rd})
        2'b10:   res_count <= res_count + 2'd1;
        2'b01:   res_count <= res_count - 2'd1;
        default: res_count <= res_count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_miss_index_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !scan_result.found) |-> scan_result.bit_index == '0)
    else $error("result without a match carries a nonzero index");

  a_first_empty_word_clears: assert property (@(posedge clk) disable iff (rst)
    (q_rd && head.first && head.word == '0) |=> !hit_valid && hit_position == '0)
    else $error("new scan kept a match from the previous one");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    res_wr |-> (res_count != 2'd2 || res_rd) && res_count != 2'd3)
    else $error("result queue overrun");
`endif

endmodule

[hdl/bit_range_first_last_scan.sv]
// Bit range scanner: finds the lowest or highest set (or clear) bit in a
// range of a memory region that streams in as 64-bit words, lowest first.
// Input channel: an item is taken at a clock edge with push high and full
// low. The word marked first carries the start bit, range length and the
// two mode flags; the word marked last closes the scan and yields one
// result. Words before any first word never match.
// Result channel: while empty is low the oldest result (found, bit_index
// relative to the start bit) is on scan_result; it is taken at an edge
// with pop high. Results queue in a two-entry buffer.
// Throughput is one word per cycle while no closing word waits for room in
// the result buffer. A last word passes through the work queue between the
// masking front end and the priority-encode back end; its result is
// registered in the result buffer when the back end takes the word.
// When the receiver stalls, the back end keeps draining words that close
// no scan; full rises once the result buffer holds two results and two
// words, the oldest of them closing a scan, wait in the work queue.
// Reset clears the range, the running match and both queues.
module bit_range_first_last_scan (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  brs_pkg::scan_item_t   scan_item,
  output logic                  empty,
  input  logic                  pop,
  output brs_pkg::scan_result_t scan_result
);

  brs_pkg::work_t ent;
  brs_pkg::work_t head;
  logic           wr_en;
  logic           q_rd;
  logic           q_empty;

  brs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .scan_item (scan_item),
    .wr_en     (wr_en),
    .ent       (ent)
  );

  brs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr_en (wr_en),
    .din   (ent),
    .rd_en (q_rd),
    .dout  (head),
    .full  (full),
    .empty (q_empty)
  );

  brs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_empty     (q_empty),
    .q_rd        (q_rd),
    .pop         (pop),
    .empty       (empty),
    .scan_result (scan_result)
  );

endmodule
